### rtl/bmo_pkg.sv
package bmo_pkg;

  // Input word function codes
  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_ADD_FIN = 2'd1;
  localparam logic [1:0] FUNC_FIN     = 2'd2;

  // Shared arithmetic unit operations
  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } alu_op_t;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

### rtl/bmo_alu.sv
module bmo_alu (
  input  logic              clk,
  input  logic              rst,
  input  bmo_pkg::alu_req_t req,
  input  logic [63:0]       opa,
  input  logic [63:0]       opb,
  output logic              done,
  output logic [63:0]       res_q,
  output logic [63:0]       res_r
);
  import bmo_pkg::*;

  logic          busy;
  logic [6:0]    cnt;
  alu_op_t       op;
  logic [63:0]   acc;
  logic [63:0]   x;
  logic [63:0]   y;
  logic [64:0]   rem;
  logic [64:0]   div_t;
  logic          div_ge;
  logic [63:0]   sq_try;

  // One bit of product, quotient or root per cycle
  assign div_t  = {rem[63:0], x[63]};
  assign div_ge = div_t >= {1'b0, y};
  assign sq_try = acc + y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        acc  <= '0;
        rem  <= '0;
        x    <= opa;
        case (req.op)
          OP_SQRT: begin
            y   <= 64'd1 << 62;
            cnt <= 7'd32;
          end
          default: begin
            y   <= opb;
            cnt <= 7'd64;
          end
        endcase
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            if (y[0]) acc <= acc + x;
            x <= x << 1;
            y <= y >> 1;
          end
          OP_DIV: begin
            if (div_ge) begin
              rem <= div_t - {1'b0, y};
              acc <= {acc[62:0], 1'b1};
            end else begin
              rem <= div_t;
              acc <= {acc[62:0], 1'b0};
            end
            x <= x << 1;
          end
          OP_SQRT: begin
            if (x >= sq_try) begin
              x   <= x - sq_try;
              acc <= (acc >> 1) + y;
            end else begin
              acc <= acc >> 1;
            end
            y <= y >> 2;
          end
          default: acc <= acc;
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res_q = acc;
  assign res_r = rem[63:0];

endmodule

### rtl/blob_moment_orientation_unit.sv
// Second-order moments and orientation of one connected component.
// Input channel (in_valid/in_stall): one word per pixel. func ADD adds the
// pixel, ADD_FIN adds it and closes the component, FIN closes it without a
// pixel. Pixel words are taken one per cycle while the block is idle.
// Output channel (out_valid/out_stall): one result word per closing word,
// with box, count, centroid (Q.8), eigenvalues (Q.8) and unit
// eigenvectors (Q1.14).
// A closing word starts a sequence of 20 to 30 multiply, divide and square
// root operations on one shared bit-serial unit (64 result bits for a
// multiply or divide, 32 for a root). How long a result takes depends on
// the vector paths taken; an empty component offers its result in the next
// cycle. in_stall is high from the closing word until the result has been
// taken.
// While the receiver stalls, the result is held and no input is taken; the
// accumulators clear when the result is taken.
// Reset clears the accumulators and near_zero; the first pixel after it
// starts a fresh component. near_zero is written with cfg_we/cfg_wdata.
module blob_moment_orientation_unit #(
  parameter int COORD_BITS = 12,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [11:0] pix_x,
  input  logic [11:0] pix_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [27:0] x_bounds,
  output logic [27:0] y_bounds,
  output logic [20:0] pixel_count,
  output logic [19:0] center_col,
  output logic [19:0] center_row,
  output logic [29:0] eigen_major,
  output logic [29:0] eigen_minor,
  output logic signed [15:0] major_dir_x,
  output logic signed [15:0] major_dir_y,
  output logic signed [15:0] minor_dir_x,
  output logic signed [15:0] minor_dir_y,
  output logic        overflowed
);
  import bmo_pkg::*;

  localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam logic [11:0] CMASK = 12'((64'd1 << CW) - 64'd1);
  localparam logic [20:0] CAP =
    21'((MAX_PIXELS < 2097151) ? MAX_PIXELS : 2097151);
  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [63:0] EIG_MAX = 64'h3FFF_FFFF;

  // Sequencer steps
  localparam logic [4:0] P_CCOL = 5'd0,  P_CROW = 5'd1;
  localparam logic [4:0] P_NXX  = 5'd2,  P_XX   = 5'd3;
  localparam logic [4:0] P_NYY  = 5'd4,  P_YY   = 5'd5;
  localparam logic [4:0] P_NXY  = 5'd6,  P_XY   = 5'd7;
  localparam logic [4:0] P_CX0  = 5'd8,  P_CX1  = 5'd9,  P_CX2 = 5'd10;
  localparam logic [4:0] P_CY0  = 5'd11, P_CY1  = 5'd12, P_CY2 = 5'd13;
  localparam logic [4:0] P_CZ0  = 5'd14, P_CZ1  = 5'd15, P_CZ2 = 5'd16;
  localparam logic [4:0] P_DD   = 5'd17, P_CC   = 5'd18, P_ROOT = 5'd19;
  localparam logic [4:0] P_AX   = 5'd20, P_AY   = 5'd21, P_NORM = 5'd22;
  localparam logic [4:0] P_MX   = 5'd23, P_MY   = 5'd24;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t      state;
  logic [15:0] near_zero;

  logic [11:0] lowest_col, highest_col, lowest_row, highest_row;
  logic [20:0] count_seen;
  logic [31:0] sum_col, sum_row;
  logic [43:0] sum_col_sq, sum_row_sq, sum_col_row;
  logic        dropped_flag;

  logic [4:0]  pc;
  logic        issued;
  logic        vsel;
  logic        back_ax;
  logic [63:0] ra, tq, tr;
  logic [63:0] dxx, dyy, dxy, cxx, cyy, cxy;
  logic        neg;
  logic [63:0] major, minor, norm;
  logic [19:0] ccol, crow;
  logic [15:0] mjx, mjy, mnx, mny;

  alu_req_t    req;
  logic [63:0] opa, opb, res_q, res_r;
  logic        done;

  logic        acc_in, fin_in;
  logic [11:0] px, py;
  logic [63:0] n64, nz64, scxy, vx, vy, ax, ay, diff, trace, root_sum;
  logic [63:0] cap_x, cap_y;
  logic [15:0] vout_x, vout_y;

  function automatic logic [15:0] sat_q14(input logic [63:0] c);
    logic signed [63:0] v;
    v = $signed(c << 6);
    if (v > 64'sd16384) return 16'sd16384;
    if (v < -64'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic [15:0] unit_q14(input logic [63:0] m, input logic sgn);
    logic [15:0] mag;
    mag = (m > 64'(ONE_Q14)) ? ONE_Q14 : m[15:0];
    return sgn ? (16'd0 - mag) : mag;
  endfunction

  assign acc_in = in_valid && !in_stall && (func == FUNC_ADD || func == FUNC_ADD_FIN);
  assign fin_in = in_valid && !in_stall && (func == FUNC_ADD_FIN || func == FUNC_FIN);
  assign px     = pix_x & CMASK;
  assign py     = pix_y & CMASK;

  assign n64   = {43'd0, count_seen};
  assign nz64  = {48'd0, near_zero};
  assign scxy  = neg ? (64'd0 - cxy) : cxy;
  assign vx    = scxy;
  assign vy    = (vsel ? minor : major) - cxx;
  assign ax    = vx[63] ? (64'd0 - vx) : vx;
  assign ay    = vy[63] ? (64'd0 - vy) : vy;
  assign diff  = (cxx >= cyy) ? (cxx - cyy) : (cyy - cxx);
  assign trace = cxx + cyy;
  assign root_sum = trace + res_q;
  assign cap_x = tq;
  assign cap_y = res_q;
  assign vout_x = unit_q14(cap_x, vx[63]);
  assign vout_y = unit_q14(cap_y, vy[63]);

  // Loop back for the minor vector once the major one is finished
  assign back_ax = !vsel &&
                   ((pc == P_NORM && (res_q == '0 || res_q <= nz64)) || pc == P_MY);

  // Operand and operation for each step
  always_comb begin
    req.start = (state == S_CALC) && !issued;
    req.op    = OP_DIV;
    opa       = '0;
    opb       = n64;
    case (pc)
      P_CCOL: opa = ({32'd0, sum_col} << 8) + (n64 >> 1);
      P_CROW: opa = ({32'd0, sum_row} << 8) + (n64 >> 1);
      P_NXX: begin req.op = OP_MUL; opa = n64; opb = {20'd0, sum_col_sq}; end
      P_XX:  begin req.op = OP_MUL; opa = {32'd0, sum_col}; opb = {32'd0, sum_col}; end
      P_NYY: begin req.op = OP_MUL; opa = n64; opb = {20'd0, sum_row_sq}; end
      P_YY:  begin req.op = OP_MUL; opa = {32'd0, sum_row}; opb = {32'd0, sum_row}; end
      P_NXY: begin req.op = OP_MUL; opa = n64; opb = {20'd0, sum_col_row}; end
      P_XY:  begin req.op = OP_MUL; opa = {32'd0, sum_col}; opb = {32'd0, sum_row}; end
      P_CX0: opa = dxx;
      P_CY0: opa = dyy;
      P_CZ0: opa = dxy;
      P_CX1, P_CY1, P_CZ1: opa = tr << 8;
      P_CX2, P_CY2, P_CZ2: opa = tq;
      P_DD:  begin req.op = OP_MUL; opa = diff; opb = diff; end
      P_CC:  begin req.op = OP_MUL; opa = cxy; opb = cxy; end
      P_ROOT: begin req.op = OP_SQRT; opa = ra; end
      P_AX:  begin req.op = OP_MUL; opa = ax; opb = ax; end
      P_AY:  begin req.op = OP_MUL; opa = ay; opb = ay; end
      P_NORM: begin req.op = OP_SQRT; opa = ra; end
      P_MX: begin opa = (ax << 14) + (norm >> 1); opb = norm; end
      P_MY: begin opa = (ay << 14) + (norm >> 1); opb = norm; end
      default: opa = '0;
    endcase
  end

  bmo_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .opa   (opa),
    .opb   (opb),
    .done  (done),
    .res_q (res_q),
    .res_r (res_r)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero <= '0;
    end else if (cfg_we) begin
      near_zero <= cfg_wdata;
    end
  end

  // Accumulate pixels; clear once the result is taken
  always_ff @(posedge clk) begin
    if (rst || (out_valid && !out_stall)) begin
      lowest_col   <= '0;
      highest_col  <= '0;
      lowest_row   <= '0;
      highest_row  <= '0;
      count_seen   <= '0;
      sum_col      <= '0;
      sum_row      <= '0;
      sum_col_sq   <= '0;
      sum_row_sq   <= '0;
      sum_col_row  <= '0;
      dropped_flag <= 1'b0;
    end else if (acc_in) begin
      if (count_seen >= CAP) begin
        dropped_flag <= 1'b1;
      end else begin
        if (count_seen == '0 || px < lowest_col)  lowest_col  <= px;
        if (count_seen == '0 || px > highest_col) highest_col <= px;
        if (count_seen == '0 || py < lowest_row)  lowest_row  <= py;
        if (count_seen == '0 || py > highest_row) highest_row <= py;
        count_seen  <= count_seen + 21'd1;
        sum_col     <= sum_col + {20'd0, px};
        sum_row     <= sum_row + {20'd0, py};
        sum_col_sq  <= sum_col_sq + {20'd0, {12'd0, px} * {12'd0, px}};
        sum_row_sq  <= sum_row_sq + {20'd0, {12'd0, py} * {12'd0, py}};
        sum_col_row <= sum_col_row + {20'd0, {12'd0, px} * {12'd0, py}};
      end
    end
  end

  // Sequencer: issue one operation, write its result back, advance
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= P_CCOL;
      issued <= 1'b0;
      vsel   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fin_in) begin
            pc     <= P_CCOL;
            issued <= 1'b0;
            vsel   <= 1'b0;
            if (func == FUNC_FIN && count_seen == '0) begin
              ccol  <= '0;
              crow  <= '0;
              major <= '0;
              minor <= '0;
              mjx   <= ONE_Q14;
              mjy   <= '0;
              mnx   <= '0;
              mny   <= ONE_Q14;
              state <= S_SEND;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (!issued) issued <= 1'b1;
          if (done) begin
            issued <= 1'b0;
            pc     <= back_ax ? P_AX : (pc + 5'd1);
            case (pc)
              P_CCOL: ccol <= res_q[19:0];
              P_CROW: crow <= res_q[19:0];
              P_NXX, P_NYY, P_NXY: ra <= res_q;
              P_XX: dxx <= (ra >= res_q) ? (ra - res_q) : '0;
              P_YY: dyy <= (ra >= res_q) ? (ra - res_q) : '0;
              P_XY: begin
                neg <= ra < res_q;
                dxy <= (ra < res_q) ? (res_q - ra) : (ra - res_q);
              end
              P_CX0, P_CY0, P_CZ0: begin
                tq <= res_q;
                tr <= res_r;
              end
              P_CX1, P_CY1, P_CZ1: tq <= (tq << 8) + res_q;
              P_CX2: cxx <= res_q;
              P_CY2: cyy <= res_q;
              P_CZ2: cxy <= res_q;
              P_DD:  ra <= res_q;
              P_CC:  ra <= ra + (res_q << 2);
              P_ROOT: begin
                major <= root_sum >> 1;
                minor <= (trace >= res_q) ? ((trace - res_q) >> 1) : '0;
                if (cxy <= nz64) begin
                  // Near-zero cross term: axis vectors
                  if (cxx >= cyy) begin
                    mjx <= ONE_Q14; mjy <= '0; mnx <= '0; mny <= ONE_Q14;
                  end else begin
                    mjx <= '0; mjy <= ONE_Q14; mnx <= ONE_Q14; mny <= '0;
                  end
                  state <= S_SEND;
                end
              end
              P_AX: ra <= res_q;
              P_AY: ra <= ra + res_q;
              P_NORM: begin
                norm <= res_q;
                if (res_q == '0 || res_q <= nz64) begin
                  // Near-zero norm: scale without normalising
                  if (!vsel) begin
                    mjx <= sat_q14(vx); mjy <= sat_q14(vy);
                    vsel <= 1'b1;
                  end else begin
                    mnx <= sat_q14(vx); mny <= sat_q14(vy);
                    state <= S_SEND;
                  end
                end
              end
              P_MX: tq <= res_q;
              P_MY: begin
                if (!vsel) begin
                  mjx <= vout_x; mjy <= vout_y;
                  vsel <= 1'b1;
                end else begin
                  mnx <= vout_x; mny <= vout_y;
                  state <= S_SEND;
                end
              end
              default: state <= S_SEND;
            endcase
          end
        end
        S_SEND: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Ports
  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_SEND);
  assign x_bounds    = {highest_col, 4'd0, lowest_col};
  assign y_bounds    = {highest_row, 4'd0, lowest_row};
  assign pixel_count = count_seen;
  assign center_col  = ccol;
  assign center_row  = crow;
  assign eigen_major = (major > EIG_MAX) ? EIG_MAX[29:0] : major[29:0];
  assign eigen_minor = (minor > EIG_MAX) ? EIG_MAX[29:0] : minor[29:0];
  assign major_dir_x = mjx;
  assign major_dir_y = mjy;
  assign minor_dir_x = mnx;
  assign minor_dir_y = mny;
  assign overflowed  = dropped_flag;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count_seen <= CAP) else $error("pixel count beyond capacity");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_CALC) else $error("arithmetic result outside calculation");

  a_fin_stalls: assert property (@(posedge clk) disable iff (rst)
    fin_in |=> in_stall) else $error("closing word did not stop input");

  a_clear_after_send: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> count_seen == '0 && !dropped_flag)
    else $error("accumulators not cleared after result");
`endif

endmodule

### test/tb_blob_moment_orientation_unit.sv
module tb_blob_moment_orientation_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bmo_pkg::*;

  // Code with no meaning: the block drops the word
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CAP = 1048576;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int ONE_Q14 = 16384;

  typedef struct {
    logic [27:0] xb, yb;
    logic [20:0] cnt;
    logic [19:0] ccol, crow;
    logic [29:0] emaj, emin;
    logic [15:0] mjx, mjy, mnx, mny;
    logic        ovf;
  } moments_t;

  typedef struct {
    logic [1:0]  f;
    logic [11:0] x, y;
    bit          typed;
    moments_t    want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] func = FUNC_ADD;
  logic [11:0] pix_x = '0, pix_y = '0;
  logic out_valid;
  logic out_stall = 1;
  logic [27:0] x_bounds, y_bounds;
  logic [20:0] pixel_count;
  logic [19:0] center_col, center_row;
  logic [29:0] eigen_major, eigen_minor;
  logic signed [15:0] major_dir_x, major_dir_y, minor_dir_x, minor_dir_y;
  logic overflowed;

  blob_moment_orientation_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .pix_x(pix_x),
    .pix_y(pix_y), .out_valid(out_valid), .out_stall(out_stall),
    .x_bounds(x_bounds), .y_bounds(y_bounds), .pixel_count(pixel_count),
    .center_col(center_col), .center_row(center_row),
    .eigen_major(eigen_major), .eigen_minor(eigen_minor),
    .major_dir_x(major_dir_x), .major_dir_y(major_dir_y),
    .minor_dir_x(minor_dir_x), .minor_dir_y(minor_dir_y),
    .overflowed(overflowed)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Mirror of the accumulators and threshold
  longint unsigned thresh;
  longint unsigned lo_c, hi_c, lo_r, hi_r, npix;
  longint unsigned s_c, s_r, s_cc, s_rr, s_cr;
  bit drop_seen;

  moments_t pending_moments[$];
  int fails = 0;
  int n_blobs = 0, n_words = 0, n_checked = 0;
  int quiet_cnt = 0;
  bit no_idle = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cov_fix(longint unsigned d, longint unsigned n);
    longint unsigned q = d / n, r = d % n;
    return ((q << 8) + ((r << 8) / n)) / n;
  endfunction

  function automatic logic [15:0] clamp_dir(longint c);
    longint v = c * 64;
    if (v > ONE_Q14) v = ONE_Q14;
    if (v < -ONE_Q14) v = -ONE_Q14;
    return v[15:0];
  endfunction

  function automatic void unit_dir(longint vx, longint vy,
                                   output logic [15:0] ox, output logic [15:0] oy);
    longint unsigned ax = vx < 0 ? -vx : vx;
    longint unsigned ay = vy < 0 ? -vy : vy;
    longint unsigned nrm = int_root(ax * ax + ay * ay);
    longint unsigned mx, my;
    if (nrm == 0 || nrm <= thresh) begin
      ox = clamp_dir(vx);
      oy = clamp_dir(vy);
      return;
    end
    mx = (ax * ONE_Q14 + nrm / 2) / nrm;
    my = (ay * ONE_Q14 + nrm / 2) / nrm;
    if (mx > ONE_Q14) mx = ONE_Q14;
    if (my > ONE_Q14) my = ONE_Q14;
    ox = vx < 0 ? 16'(-mx) : 16'(mx);
    oy = vy < 0 ? 16'(-my) : 16'(my);
  endfunction

  function automatic void clear_blob();
    lo_c = 0; hi_c = 0; lo_r = 0; hi_r = 0; npix = 0;
    s_c = 0; s_r = 0; s_cc = 0; s_rr = 0; s_cr = 0;
    drop_seen = 0;
  endfunction

  function automatic moments_t close_blob();
    moments_t m;
    longint unsigned n = npix, a, b, dxx, dyy, dxy, cxx, cyy, cxy;
    longint unsigned diff, rt, tr, mj, mn;
    bit neg;
    longint scxy;
    m.xb = 28'(lo_c | (hi_c << 16));
    m.yb = 28'(lo_r | (hi_r << 16));
    m.cnt = n[20:0];
    m.ovf = drop_seen;
    if (n == 0) begin
      m.ccol = 0; m.crow = 0; m.emaj = 0; m.emin = 0;
      m.mjx = ONE_Q14; m.mjy = 0; m.mnx = 0; m.mny = ONE_Q14;
      return m;
    end
    m.ccol = 20'(((s_c << 8) + n / 2) / n);
    m.crow = 20'(((s_r << 8) + n / 2) / n);
    a = n * s_cc; b = s_c * s_c; dxx = a >= b ? a - b : 0;
    a = n * s_rr; b = s_r * s_r; dyy = a >= b ? a - b : 0;
    a = n * s_cr; b = s_c * s_r; neg = a < b; dxy = neg ? b - a : a - b;
    cxx = cov_fix(dxx, n);
    cyy = cov_fix(dyy, n);
    cxy = cov_fix(dxy, n);
    scxy = neg ? -longint'(cxy) : longint'(cxy);
    diff = cxx >= cyy ? cxx - cyy : cyy - cxx;
    rt = int_root(diff * diff + 4 * cxy * cxy);
    tr = cxx + cyy;
    mj = (tr + rt) / 2;
    mn = tr >= rt ? (tr - rt) / 2 : 0;
    m.emaj = mj > 64'h3FFFFFFF ? 30'h3FFFFFFF : mj[29:0];
    m.emin = mn > 64'h3FFFFFFF ? 30'h3FFFFFFF : mn[29:0];
    if (cxy > thresh) begin
      unit_dir(scxy, longint'(mj) - longint'(cxx), m.mjx, m.mjy);
      unit_dir(scxy, longint'(mn) - longint'(cxx), m.mnx, m.mny);
    end else if (cxx >= cyy) begin
      unit_dir(256, 0, m.mjx, m.mjy);
      unit_dir(0, 256, m.mnx, m.mny);
    end else begin
      unit_dir(0, 256, m.mjx, m.mjy);
      unit_dir(256, 0, m.mnx, m.mny);
    end
    return m;
  endfunction

  // Advance the mirror by one word; report whether a result follows
  function automatic bit predict_moments(logic [1:0] f, logic [11:0] x, logic [11:0] y,
                                         output moments_t m);
    longint unsigned px = x, py = y;
    if (f == FUNC_NONE) return 0;
    if (f == FUNC_ADD || f == FUNC_ADD_FIN) begin
      if (npix >= CAP) drop_seen = 1;
      else begin
        if (npix == 0) begin
          lo_c = px; hi_c = px; lo_r = py; hi_r = py;
        end else begin
          if (px < lo_c) lo_c = px;
          if (px > hi_c) hi_c = px;
          if (py < lo_r) lo_r = py;
          if (py > hi_r) hi_r = py;
        end
        npix++;
        s_c = (s_c + px) & 64'hFFFFFFFF;
        s_r = (s_r + py) & 64'hFFFFFFFF;
        s_cc = (s_cc + px * px) & 64'hFFFFFFFFFFF;
        s_rr = (s_rr + py * py) & 64'hFFFFFFFFFFF;
        s_cr = (s_cr + px * py) & 64'hFFFFFFFFFFF;
      end
    end
    if (f == FUNC_ADD) return 0;
    m = close_blob();
    clear_blob();
    return 1;
  endfunction

  // Drive one word and hold it until taken
  task automatic send_word(logic [1:0] f, logic [11:0] x, logic [11:0] y,
                           bit typed, moments_t want);
    moments_t m;
    bit has;
    if (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    pix_x <= x;
    pix_y <= y;
    do @(posedge clk); while (in_stall);
    has = predict_moments(f, x, y, m);
    if (has) begin
      pending_moments.push_back(typed ? want : m);
      n_blobs++;
    end
    n_words++;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (pending_moments.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_thresh(logic [15:0] v);
    drain_results();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    thresh = v;
  endtask

  // One component of random shape; ends with a closing word
  task automatic send_blob();
    moments_t none;
    int sz, cx, cy, spread, kind, dx, dy;
    logic [11:0] x, y;
    sz = ($urandom_range(99) < 5) ? $urandom_range(200, 50) : $urandom_range(12);
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    spread = $urandom_range(3) == 0 ? 4095 : $urandom_range(40, 1);
    kind = $urandom_range(3);
    for (int i = 0; i < sz; i++) begin
      dx = $urandom_range(2 * spread) - spread;
      case (kind)
        0: dy = dx + $urandom_range(2) - 1;
        1: dy = -dx + $urandom_range(2) - 1;
        default: dy = $urandom_range(2 * spread) - spread;
      endcase
      x = 12'(cx + dx);
      y = 12'(cy + dy);
      if ($urandom_range(99) < 3) send_word(FUNC_NONE, 12'($urandom), 12'($urandom), 0, none);
      if (i == sz - 1 && $urandom_range(1)) begin
        send_word(FUNC_ADD_FIN, x, y, 0, none);
        return;
      end
      send_word(FUNC_ADD, x, y, 0, none);
    end
    send_word(FUNC_FIN, 12'($urandom), 12'($urandom), 0, none);
  endtask

  function automatic moments_t lone_pixel(logic [11:0] v);
    moments_t m;
    m.xb = 28'({v, 16'(v)});
    m.yb = 28'({v, 16'(v)});
    m.cnt = 1;
    m.ccol = 20'(v) << 8;
    m.crow = 20'(v) << 8;
    m.emaj = 0; m.emin = 0;
    m.mjx = ONE_Q14; m.mjy = 0; m.mnx = 0; m.mny = ONE_Q14;
    m.ovf = 0;
    return m;
  endfunction

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    moments_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_moments.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        e = pending_moments.pop_front();
        n_checked++;
        if (x_bounds !== e.xb) begin $error("x_bounds exp %h got %h", e.xb, x_bounds); fails++; end
        if (y_bounds !== e.yb) begin $error("y_bounds exp %h got %h", e.yb, y_bounds); fails++; end
        if (pixel_count !== e.cnt) begin
          $error("pixel_count exp %0d got %0d", e.cnt, pixel_count); fails++;
        end
        if (center_col !== e.ccol) begin
          $error("center_col exp %0d got %0d", e.ccol, center_col); fails++;
        end
        if (center_row !== e.crow) begin
          $error("center_row exp %0d got %0d", e.crow, center_row); fails++;
        end
        if (eigen_major !== e.emaj) begin
          $error("eigen_major exp %0d got %0d", e.emaj, eigen_major); fails++;
        end
        if (eigen_minor !== e.emin) begin
          $error("eigen_minor exp %0d got %0d", e.emin, eigen_minor); fails++;
        end
        if (major_dir_x !== e.mjx) begin
          $error("major_dir_x exp %0d got %0d", $signed(e.mjx), major_dir_x); fails++;
        end
        if (major_dir_y !== e.mjy) begin
          $error("major_dir_y exp %0d got %0d", $signed(e.mjy), major_dir_y); fails++;
        end
        if (minor_dir_x !== e.mnx) begin
          $error("minor_dir_x exp %0d got %0d", $signed(e.mnx), minor_dir_x); fails++;
        end
        if (minor_dir_y !== e.mny) begin
          $error("minor_dir_y exp %0d got %0d", $signed(e.mny), minor_dir_y); fails++;
        end
        if (overflowed !== e.ovf) begin
          $error("overflowed exp %0d got %0d", e.ovf, overflowed); fails++;
        end
      end
    end
    out_stall <= !no_idle && $urandom_range(99) < 20;
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    moments_t blank, empty_blob;
    blank = '{default: '0};
    empty_blob = blank;
    empty_blob.mjx = ONE_Q14;
    empty_blob.mny = ONE_Q14;
    thresh = 0;
    clear_blob();

    // Directed rows: extremes, every code, empty and pixel-less closes
    rows.push_back('{FUNC_FIN, 12'h0, 12'h0, 1, empty_blob});
    rows.push_back('{FUNC_ADD_FIN, 12'hFFF, 12'hFFF, 1, lone_pixel(12'hFFF)});
    rows.push_back('{FUNC_ADD_FIN, 12'h0, 12'h0, 1, lone_pixel(12'h0)});
    rows.push_back('{FUNC_ADD, 12'h0, 12'h0, 0, blank});
    rows.push_back('{FUNC_NONE, 12'hFFF, 12'hFFF, 0, blank});
    rows.push_back('{FUNC_ADD, 12'hFFF, 12'hFFF, 0, blank});
    rows.push_back('{FUNC_ADD_FIN, 12'h0, 12'hFFF, 0, blank});
    rows.push_back('{FUNC_ADD, 12'd10, 12'd20, 0, blank});
    rows.push_back('{FUNC_ADD, 12'd20, 12'd10, 0, blank});
    rows.push_back('{FUNC_ADD_FIN, 12'd30, 12'd0, 0, blank});
    rows.push_back('{FUNC_ADD, 12'd5, 12'd7, 0, blank});
    rows.push_back('{FUNC_ADD, 12'd6, 12'd9, 0, blank});
    rows.push_back('{FUNC_FIN, 12'hAAA, 12'h555, 0, blank});
    rows.push_back('{FUNC_ADD, 12'd100, 12'd100, 0, blank});
    rows.push_back('{FUNC_ADD, 12'd103, 12'd100, 0, blank});
    rows.push_back('{FUNC_FIN, 12'h0, 12'h0, 0, blank});
    rows.push_back('{FUNC_FIN, 12'h0, 12'h0, 1, empty_blob});

    repeat (9) @(posedge clk);
    rst <= 0;
    write_thresh(16'd0);
    foreach (rows[i]) send_word(rows[i].f, rows[i].x, rows[i].y, rows[i].typed, rows[i].want);

    // Random phases over several thresholds, one without any idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_thresh(16'hFFFF);
        1: write_thresh(16'd0);
        2: write_thresh(16'($urandom_range(600, 1)));
        default: write_thresh(16'($urandom));
      endcase
      no_idle = (ph == 1);
      while (n_words < 250 * (ph + 1) + rows.size()) send_blob();
    end
    no_idle = 0;

    drain_results();
    repeat (20) @(posedge clk);
    $display("%0d words sent, %0d components closed, %0d results checked",
             n_words, n_blobs, n_checked);
    $display("thresholds swept from 0 to 65535, with and without idling");
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### files.f
rtl/bmo_pkg.sv
rtl/bmo_alu.sv
rtl/blob_moment_orientation_unit.sv
test/tb_blob_moment_orientation_unit.sv
